// ----- rtl/plst_pkg.sv -----
// shared types, sizes, operation codes and helpers for the positional list store
package plst_pkg;

    localparam int CAPACITY   = 16;
    localparam int ELEM_WIDTH = 32;

    // widths of the fixed request and result fields
    localparam int FUNC_W     = 3;
    localparam int POS_W      = 8;
    localparam int DATA_W     = 32;
    localparam int CNT_OUT_W  = 8;

    // count holds 0..CAPACITY, compares are done one bit wider than a position
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W      = POS_W + 1;

    typedef logic [FUNC_W-1:0]     t_func;
    typedef logic [ELEM_WIDTH-1:0] t_slot;
    typedef logic [CNT_W-1:0]      t_count;

    localparam t_func FUNC_INSERT = 3'd0;
    localparam t_func FUNC_REMOVE = 3'd1;
    localparam t_func FUNC_GET    = 3'd2;
    localparam t_func FUNC_SET    = 3'd3;
    localparam t_func FUNC_CLEAR  = 3'd4;

    // per-cell update controls, at most one is set in a cycle
    typedef struct packed {
        logic load;
        logic shift_up;
        logic shift_dn;
    } t_cell_ctl;

    // fit a request data word to the slot width
    function automatic t_slot f_to_slot(input logic [DATA_W-1:0] elem);
        return t_slot'(elem);
    endfunction

    // fit a slot back to the result data width
    function automatic logic [DATA_W-1:0] f_to_data(input t_slot slot);
        return DATA_W'(slot);
    endfunction

endpackage

// ----- rtl/plst_cell.sv -----
// one list slot: loads the request word or takes its left or right neighbor
module plst_cell (
    input  logic               i_clk,
    input  plst_pkg::t_cell_ctl i_ctl,
    input  plst_pkg::t_slot    i_elem,
    input  plst_pkg::t_slot    i_left,
    input  plst_pkg::t_slot    i_right,
    output plst_pkg::t_slot    o_slot
);
    import plst_pkg::*;

    t_slot r_slot;
    t_slot n_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.load) begin
            n_slot = i_elem;
        end else if (i_ctl.shift_up) begin
            n_slot = i_left;
        end else if (i_ctl.shift_dn) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;

endmodule

// ----- rtl/positional_list_store_top.sv -----
// top level of the positional list store: request decode, slot chain, result register
//
// A list of up to CAPACITY words kept in position order, positions counted from 1.
// Requests enter on the s_axis channel: func (insert, remove, get, set, clear),
// a one-based position and a data word. Every request gives exactly one result on
// the m_axis channel: ok, read data (only for a successful get, else 0) and the
// entry count after the request.
// A request is carried out in the cycle it is taken: every slot cell decides on
// its own whether to load the word, take its left neighbor (insert) or its right
// neighbor (remove), so all shifts happen in the same cycle. The result shows up in
// the next cycle, and the block takes one request per cycle while results are taken.
// The result sits in an output register; a new request is taken while that
// register is empty or being emptied, so a stalled receiver stalls the sender
// only once the one pending result is not taken.
// A synchronous low reset empties the list and drops any pending result; slot
// contents are not cleared and are never read before they are written.
module positional_list_store_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // func[2:0], position[10:3], element[42:11]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // ok[0], read_data[32:1], count[40:33]
);
    import plst_pkg::*;

    t_func              w_func;
    logic [POS_W-1:0]   w_pos;
    logic [DATA_W-1:0]  w_elem;
    t_slot              w_elem_slot;
    logic               w_accept;

    logic [CMP_W-1:0]   w_pos_c;
    logic [CMP_W-1:0]   w_cnt_c;
    logic               w_pos_nz;
    logic               w_in_list;
    logic               w_ins_ok;
    logic               w_rem_ok;
    logic               w_get_ok;
    logic               w_set_ok;
    logic [POS_W-1:0]   w_pos_m1;
    logic [IDX_W-1:0]   w_idx;

    t_count             r_count;
    t_count             n_count;
    logic               n_ok;
    logic [DATA_W-1:0]  n_rd;

    logic               r_out_valid;
    logic               r_ok;
    logic [DATA_W-1:0]  r_rd;
    t_count             r_cnt_out;

    t_cell_ctl          w_ctl  [CAPACITY];
    t_slot              w_slot [CAPACITY];

    assign w_func      = s_axis_tdata[2:0];
    assign w_pos       = s_axis_tdata[10:3];
    assign w_elem      = s_axis_tdata[42:11];
    assign w_elem_slot = f_to_slot(w_elem);

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // validity of the position against the current count
    assign w_pos_c   = CMP_W'(w_pos);
    assign w_cnt_c   = CMP_W'(r_count);
    assign w_pos_nz  = (w_pos != '0);
    assign w_in_list = w_pos_nz && (w_pos_c <= w_cnt_c);

    assign w_ins_ok = (w_func == FUNC_INSERT) && w_pos_nz
                      && (w_pos_c <= w_cnt_c + CMP_W'(1))
                      && (w_cnt_c < CMP_W'(CAPACITY));
    assign w_rem_ok = (w_func == FUNC_REMOVE) && w_in_list;
    assign w_get_ok = (w_func == FUNC_GET) && w_in_list;
    assign w_set_ok = (w_func == FUNC_SET) && w_in_list;

    assign w_pos_m1 = w_pos - POS_W'(1);
    assign w_idx    = w_pos_m1[IDX_W-1:0];

    // per-cell controls; cell i holds position i+1
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [CMP_W-1:0] POS_HERE = CMP_W'(i + 1);
        t_slot w_left;
        t_slot w_right;

        always_comb begin
            w_ctl[i].load     = w_accept && (w_ins_ok || w_set_ok) && (w_pos_c == POS_HERE);
            // insert: positions above p up to count+1 take their left neighbor
            w_ctl[i].shift_up = w_accept && w_ins_ok && (POS_HERE > w_pos_c)
                                && (POS_HERE <= w_cnt_c + CMP_W'(1));
            // remove: positions p up to count-1 take their right neighbor
            w_ctl[i].shift_dn = w_accept && w_rem_ok && (POS_HERE >= w_pos_c)
                                && (POS_HERE < w_cnt_c);
        end

        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_slot[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_slot[i+1];
        end

        plst_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[i]),
            .i_elem  (w_elem_slot),
            .i_left  (w_left),
            .i_right (w_right),
            .o_slot  (w_slot[i])
        );
    end

    always_comb begin
        n_count = r_count;
        n_ok    = 1'b0;
        n_rd    = '0;
        case (w_func)
            FUNC_INSERT: begin
                n_ok = w_ins_ok;
                if (w_ins_ok) begin
                    n_count = r_count + t_count'(1);
                end
            end
            FUNC_REMOVE: begin
                n_ok = w_rem_ok;
                if (w_rem_ok) begin
                    n_count = r_count - t_count'(1);
                end
            end
            FUNC_GET: begin
                n_ok = w_get_ok;
                if (w_get_ok) begin
                    n_rd = f_to_data(w_slot[w_idx]);
                end
            end
            FUNC_SET: begin
                n_ok = w_set_ok;
            end
            FUNC_CLEAR: begin
                n_ok    = 1'b1;
                n_count = '0;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok      <= n_ok;
            r_rd      <= n_rd;
            r_cnt_out <= n_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, CNT_OUT_W'(r_cnt_out), r_rd, r_ok};

endmodule

// ----- test/plst_checker.sv -----
// checker for the positional list store: list predictor and result comparison
module plst_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [47:0] i_req_data,    // func[2:0], position[10:3], element[42:11]
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [47:0] i_res_data,    // ok[0], read_data[32:1], count[40:33]
    output int          o_fail_count,
    output int          o_pending,
    output int          o_list_len
);
    import plst_pkg::*;

    typedef struct packed {
        logic                 ok;
        logic [DATA_W-1:0]    read_data;
        logic [CNT_OUT_W-1:0] count;
    } t_list_result;

    t_slot        list_slots [CAPACITY];
    int           list_len = 0;
    int           fail_count = 0;
    t_list_result expected_results [$];

    // apply one request to the shadow list and return its result
    function automatic t_list_result apply_request(input t_func f, input logic [POS_W-1:0] p,
                                                   input logic [DATA_W-1:0] e);
        t_list_result r;
        int           pos;
        r   = '0;
        pos = int'(p);
        case (f)
            FUNC_INSERT: begin
                if (pos >= 1 && pos <= list_len + 1 && list_len < CAPACITY) begin
                    for (int i = list_len; i >= pos; i--)
                        list_slots[i] = list_slots[i-1];
                    list_slots[pos-1] = t_slot'(e);
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            FUNC_REMOVE: begin
                if (pos >= 1 && pos <= list_len) begin
                    for (int i = pos; i < list_len; i++)
                        list_slots[i-1] = list_slots[i];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            FUNC_GET: begin
                if (pos >= 1 && pos <= list_len) begin
                    r.read_data = DATA_W'(list_slots[pos-1]);
                    r.ok        = 1'b1;
                end
            end
            FUNC_SET: begin
                if (pos >= 1 && pos <= list_len) begin
                    list_slots[pos-1] = t_slot'(e);
                    r.ok              = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                list_len = 0;
                r.ok     = 1'b1;
            end
            default: ;
        endcase
        r.count = CNT_OUT_W'(list_len);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_list_result got;
        t_list_result want;
        if (!i_rst_n) begin
            list_len = 0;
            expected_results.delete();
        end else begin
            // a result taken in this cycle belongs to an older request
            if (i_res_valid && i_res_ready) begin
                got.ok        = i_res_data[0];
                got.read_data = i_res_data[32:1];
                got.count     = i_res_data[40:33];
                if (expected_results.size() == 0) begin
                    $error("result with no request pending: ok %0d read_data %h count %0d",
                           got.ok, got.read_data, got.count);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.ok !== want.ok) begin
                        $error("ok: expected %0d actual %0d", want.ok, got.ok);
                        fail_count++;
                    end
                    if (got.read_data !== want.read_data) begin
                        $error("read_data: expected %h actual %h", want.read_data,
                               got.read_data);
                        fail_count++;
                    end
                    if (got.count !== want.count) begin
                        $error("count: expected %0d actual %0d", want.count, got.count);
                        fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                expected_results.push_back(apply_request(i_req_data[2:0], i_req_data[10:3],
                                                         i_req_data[42:11]));
        end
        o_fail_count = fail_count;
        o_pending    = expected_results.size();
        o_list_len   = list_len;
    end

endmodule

// ----- test/tb.sv -----
// testbench top for the positional list store: stimulus, handshake pacing and verdict
module tb;
    import plst_pkg::*;

    localparam int   RANDOM_PER_PHASE = 250;
    localparam int   NUM_PHASES       = 4;
    localparam t_func FUNC_TOP        = t_func'('1);

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;    // func[2:0], position[10:3], element[42:11]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // ok[0], read_data[32:1], count[40:33]

    int fail_count;
    int pending;
    int list_len;
    int send_idle_pct = 0;
    int stall_pct = 0;

    // idle and stall percentages per phase
    int phase_idle  [NUM_PHASES] = '{0, 86, 0, 25};
    int phase_stall [NUM_PHASES] = '{0, 0, 86, 25};

    positional_list_store_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    plst_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_list_len   (list_len)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk)
        m_axis_tready = ($urandom_range(99) >= stall_pct);

    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic push_request(input t_func f, input logic [POS_W-1:0] p,
                                input logic [DATA_W-1:0] e);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {5'b0, e, p, f};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // mostly well-formed requests against the current list length, some rejects and noise
    task automatic push_random();
        t_func       f;
        int          pick;
        int          hi;
        logic [7:0]  p;
        pick = $urandom_range(99);
        if (pick < 40)      f = FUNC_INSERT;
        else if (pick < 66) f = FUNC_REMOVE;
        else if (pick < 80) f = FUNC_GET;
        else if (pick < 93) f = FUNC_SET;
        else if (pick < 96) f = FUNC_CLEAR;
        else                f = t_func'($urandom_range(FUNC_TOP, FUNC_CLEAR + 1));
        hi   = (f == FUNC_INSERT) ? list_len + 1 : ((list_len > 0) ? list_len : 1);
        pick = $urandom_range(99);
        if (pick < 80)      p = 8'($urandom_range(hi, 1));
        else if (pick < 90) p = ($urandom_range(1) != 0) ? 8'd0 : 8'(hi + 1);
        else                p = 8'($urandom_range(255));
        push_request(f, p, $urandom);
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty list, zero and out-of-range positions, data extremes
        push_request(FUNC_CLEAR,  8'd0, 32'h0);
        push_request(FUNC_GET,    8'd1, 32'h0);
        push_request(FUNC_REMOVE, 8'd1, 32'h0);
        push_request(FUNC_INSERT, 8'd0, 32'hFFFF_FFFF);
        push_request(FUNC_INSERT, 8'd2, 32'hFFFF_FFFF);
        push_request(FUNC_INSERT, 8'd1, 32'h0000_0000);
        push_request(FUNC_INSERT, 8'd2, 32'hFFFF_FFFF);
        push_request(FUNC_INSERT, 8'd1, 32'hA5A5_5A5A);
        push_request(FUNC_INSERT, 8'd2, 32'h1234_5678);
        push_request(FUNC_GET,    8'd0, 32'h0);
        push_request(FUNC_GET,    8'd1, 32'h0);
        push_request(FUNC_GET,    8'd4, 32'h0);
        push_request(FUNC_GET,    8'd5, 32'h0);
        push_request(FUNC_SET,    8'd255, 32'hDEAD_BEEF);
        push_request(FUNC_SET,    8'd3, 32'hDEAD_BEEF);
        push_request(FUNC_GET,    8'd3, 32'h0);
        push_request(FUNC_REMOVE, 8'd4, 32'h0);
        push_request(FUNC_REMOVE, 8'd1, 32'h0);
        push_request(FUNC_REMOVE, 8'd0, 32'h0);
        // unused operation codes leave the list alone
        for (int f = FUNC_CLEAR + 1; f <= int'(FUNC_TOP); f++)
            push_request(t_func'(f), 8'd1, 32'hFFFF_FFFF);
        push_request(FUNC_GET,    8'd2, 32'h0);
        push_request(FUNC_CLEAR,  8'd7, 32'h0);
        push_request(FUNC_GET,    8'd1, 32'h0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct = phase_idle[ph];
            stall_pct     = phase_stall[ph];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                push_random();
            // hold off the sender until every result is back
            wait_drained();
        end

        stall_pct = 0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/plst_pkg.sv
rtl/plst_cell.sv
rtl/positional_list_store_top.sv
test/plst_checker.sv
test/tb.sv
